// ----- rtl/pfp_pkg.sv -----
// Package for the position frame parser: register indexes, reset values,
// payload layout and the saturating Q16.16 helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfp_pkg;

   localparam int PAYLOAD_BYTES_DEF = 24;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEADER_SECOND = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TAIL_FIRST    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TAIL_SECOND   = 2'd3;

   localparam logic [7:0] HEADER_FIRST_RST  = 8'd13;
   localparam logic [7:0] HEADER_SECOND_RST = 8'd10;
   localparam logic [7:0] TAIL_FIRST_RST    = 8'd10;
   localparam logic [7:0] TAIL_SECOND_RST   = 8'd13;

   // byte offsets of the little-endian singles in the payload
   localparam int YAW_OFS = 0;
   localparam int X_OFS   = 12;
   localparam int Y_OFS   = 16;

   // 0.01745 in Q16.16, rounded
   localparam logic signed [11:0] YAW_RAD_K = 12'sd1144;
   localparam int PROD_W = 44;

   typedef logic signed [31:0] q16_type;

   localparam q16_type Q16_MAX = 32'sh7FFF_FFFF;
   localparam q16_type Q16_MIN = 32'sh8000_0000;

   function automatic q16_type sat_add(input q16_type a, input q16_type b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? Q16_MIN : Q16_MAX;
      end
      return s[31:0];
   endfunction

   function automatic q16_type sat_sub(input q16_type a, input q16_type b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? Q16_MIN : Q16_MAX;
      end
      return s[31:0];
   endfunction

   function automatic q16_type sat_neg(input q16_type a);
      return (a == Q16_MIN) ? Q16_MAX : -a;
   endfunction

   // IEEE single to Q16.16, round half away from zero, saturating, NaN -> 0
   function automatic q16_type f32_to_q16(input logic [31:0] bits);
      logic        neg;
      logic [7:0]  ex;
      logic [22:0] man;
      logic [23:0] sig;
      logic [2:0]  up;
      logic [4:0]  n_m1;
      logic [24:0] rnd;
      logic [31:0] mag;
      q16_type     res;
      neg  = bits[31];
      ex   = bits[30:23];
      man  = bits[22:0];
      sig  = {1'b1, man};
      up   = '0;
      n_m1 = '0;
      rnd  = '0;
      mag  = '0;
      if (ex == 8'hFF) begin
         res = (man != '0) ? '0 : (neg ? Q16_MIN : Q16_MAX);
      end else if (ex == 8'h00) begin
         res = '0;
      end else if (ex >= 8'd142) begin
         res = neg ? Q16_MIN : Q16_MAX;
      end else if (ex >= 8'd134) begin
         up  = 3'(ex - 8'd134);
         mag = {8'b0, sig} << up;
         res = neg ? q16_type'(-mag) : q16_type'(mag);
      end else if (ex < 8'd110) begin
         res = '0;
      end else begin
         n_m1 = 5'(8'd133 - ex);
         rnd  = {1'b0, sig} + (25'd1 << n_m1);
         mag  = 32'(rnd >> (n_m1 + 5'd1));
         res  = neg ? q16_type'(-mag) : q16_type'(mag);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/position_frame_parser_top.sv -----
// Position frame parser top level: frame state machine, payload store,
// float conversion and the running-sum result pipeline. Uses pfp_pkg.
//
// Usage:
//   req_* carries one item per handshake: a received serial byte in
//   req_tdata, or with req_tuser[0] set a restart that zeroes the sums.
//   A frame is header_first, header_second, PAYLOAD_BYTES payload bytes,
//   tail_first, tail_second. A frame whose tails match yields one item on
//   rsp_*: after the second tail byte is taken, the result passes stages
//   s1 to s4 and then raises rsp_tvalid. Other items produce nothing.
//   Throughput is one item per cycle. The single exception: while a result
//   is still in the four-stage result pipeline or waiting on rsp_*, an item
//   that would be a second tail byte is held off (req_tready low in that
//   phase only), so a stalled receiver never loses a result.
//   csr_* writes the four match bytes; write only while idle.
//   Reset (synchronous) returns the parser to header hunt, clears the
//   previous-frame values and sums and restores the default match bytes.
//   The payload store is not cleared: every byte is rewritten before use.
`timescale 1ns / 1ps
`default_nettype none

module position_frame_parser_top #(
   parameter int PAYLOAD_BYTES = pfp_pkg::PAYLOAD_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [7:0]                      req_tdata,  // rx_byte
   input  wire logic [0:0]                      req_tuser,  // operation
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // yaw_deg, yaw_radians, sum_x_out, sum_y_out, step_x, step_y, step_yaw
   output      logic [223:0]                    rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [pfp_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [pfp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(PAYLOAD_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

   localparam logic [2:0] PH_HEAD0 = 3'd0;
   localparam logic [2:0] PH_HEAD1 = 3'd1;
   localparam logic [2:0] PH_DATA  = 3'd2;
   localparam logic [2:0] PH_TAIL0 = 3'd3;
   localparam logic [2:0] PH_TAIL1 = 3'd4;

   logic [7:0] header_first_ff, header_second_ff, tail_first_ff, tail_second_ff;

   logic [2:0]       phase_ff, phase_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       payload_ff [PAYLOAD_BYTES];

   pfp_pkg::q16_type now_x_ff, now_y_ff, now_yaw_ff;
   pfp_pkg::q16_type now_x_in, now_y_in, now_yaw_in;
   pfp_pkg::q16_type last_x_ff, last_y_ff, last_yaw_ff;
   pfp_pkg::q16_type last_x_in, last_y_in, last_yaw_in;
   pfp_pkg::q16_type dx_ff, dy_ff, dyaw_ff, dx_in, dy_in, dyaw_in;
   pfp_pkg::q16_type acc_x_ff, acc_y_ff, acc_yaw_ff, acc_x_in, acc_y_in, acc_yaw_in;
   pfp_pkg::q16_type sum_x_ff, sum_y_ff, sum_yaw_ff, sum_x_in, sum_y_in, sum_yaw_in;
   pfp_pkg::q16_type angle_ff, angle_in, rad_ff, rad_in;
   logic signed [pfp_pkg::PROD_W-1:0] prod_ff, prod_in, rsum;
   pfp_pkg::q16_type acc_x_new, acc_y_new, acc_yaw_new;

   logic s1_ff, s2_ff, s3_ff, s4_ff, rsp_tvalid_ff, rsp_tvalid_in;

   logic accept, restart, rx, busy, frame_done, pay_we;

   assign busy       = s1_ff | s2_ff | s3_ff | s4_ff | rsp_tvalid_ff;
   assign req_tready = !((phase_ff == PH_TAIL1) && busy);
   assign accept     = req_tvalid && req_tready;
   assign restart    = accept && req_tuser[0];
   assign rx         = accept && !req_tuser[0];
   assign frame_done = rx && (phase_ff == PH_TAIL1) && (req_tdata == tail_second_ff);
   assign pay_we     = rx && (phase_ff == PH_DATA);

   assign acc_x_new   = pfp_pkg::sat_add(acc_x_ff, dx_ff);
   assign acc_y_new   = pfp_pkg::sat_add(acc_y_ff, dy_ff);
   assign acc_yaw_new = pfp_pkg::sat_add(acc_yaw_ff, dyaw_ff);

   assign rsum = prod_ff + (prod_ff[pfp_pkg::PROD_W-1] ? pfp_pkg::PROD_W'(32767)
                                                      : pfp_pkg::PROD_W'(32768));

   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      now_x_in    = now_x_ff;
      now_y_in    = now_y_ff;
      now_yaw_in  = now_yaw_ff;
      last_x_in   = last_x_ff;
      last_y_in   = last_y_ff;
      last_yaw_in = last_yaw_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      dyaw_in     = dyaw_ff;
      if (rx) begin
         case (phase_ff)
            PH_HEAD0: begin
               if (req_tdata == header_first_ff) phase_in = PH_HEAD1;
            end
            PH_HEAD1: begin
               if (req_tdata == header_second_ff) begin
                  phase_in = PH_DATA;
                  cnt_in   = '0;
               end else begin
                  phase_in = PH_HEAD0;
               end
            end
            PH_DATA: begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) phase_in = PH_TAIL0;
            end
            PH_TAIL0: begin
               now_yaw_in = pfp_pkg::f32_to_q16({payload_ff[pfp_pkg::YAW_OFS+3],
                  payload_ff[pfp_pkg::YAW_OFS+2], payload_ff[pfp_pkg::YAW_OFS+1],
                  payload_ff[pfp_pkg::YAW_OFS]});
               now_x_in = pfp_pkg::f32_to_q16({payload_ff[pfp_pkg::X_OFS+3],
                  payload_ff[pfp_pkg::X_OFS+2], payload_ff[pfp_pkg::X_OFS+1],
                  payload_ff[pfp_pkg::X_OFS]});
               now_y_in = pfp_pkg::f32_to_q16({payload_ff[pfp_pkg::Y_OFS+3],
                  payload_ff[pfp_pkg::Y_OFS+2], payload_ff[pfp_pkg::Y_OFS+1],
                  payload_ff[pfp_pkg::Y_OFS]});
               phase_in = (req_tdata == tail_first_ff) ? PH_TAIL1 : PH_HEAD0;
            end
            PH_TAIL1: begin
               phase_in = PH_HEAD0;
               if (req_tdata == tail_second_ff) begin
                  dx_in       = pfp_pkg::sat_sub(now_x_ff, last_x_ff);
                  dy_in       = pfp_pkg::sat_sub(now_y_ff, last_y_ff);
                  dyaw_in     = pfp_pkg::sat_sub(now_yaw_ff, last_yaw_ff);
                  last_x_in   = now_x_ff;
                  last_y_in   = now_y_ff;
                  last_yaw_in = now_yaw_ff;
               end
            end
            default: phase_in = PH_HEAD0;
         endcase
      end
   end

   // result path: sums, negate, multiply, round
   always_comb begin
      acc_x_in   = acc_x_ff;
      acc_y_in   = acc_y_ff;
      acc_yaw_in = acc_yaw_ff;
      sum_x_in   = sum_x_ff;
      sum_y_in   = sum_y_ff;
      sum_yaw_in = sum_yaw_ff;
      angle_in   = angle_ff;
      prod_in    = prod_ff;
      rad_in     = rad_ff;
      if (s1_ff) begin
         acc_x_in   = acc_x_new;
         acc_y_in   = acc_y_new;
         acc_yaw_in = acc_yaw_new;
         sum_x_in   = acc_x_new;
         sum_y_in   = acc_y_new;
         sum_yaw_in = acc_yaw_new;
      end
      // a restart taken in the add cycle comes after that frame
      if (restart) begin
         acc_x_in   = '0;
         acc_y_in   = '0;
         acc_yaw_in = '0;
      end
      if (s2_ff) angle_in = pfp_pkg::sat_neg(sum_yaw_ff);
      if (s3_ff) prod_in = pfp_pkg::PROD_W'(angle_ff) * pfp_pkg::PROD_W'(pfp_pkg::YAW_RAD_K);
      if (s4_ff) rad_in = pfp_pkg::q16_type'(rsum >>> 16);
      if (s4_ff) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= pfp_pkg::HEADER_FIRST_RST;
         header_second_ff <= pfp_pkg::HEADER_SECOND_RST;
         tail_first_ff    <= pfp_pkg::TAIL_FIRST_RST;
         tail_second_ff   <= pfp_pkg::TAIL_SECOND_RST;
         phase_ff         <= PH_HEAD0;
         cnt_ff           <= '0;
         last_x_ff        <= '0;
         last_y_ff        <= '0;
         last_yaw_ff      <= '0;
         acc_x_ff         <= '0;
         acc_y_ff         <= '0;
         acc_yaw_ff       <= '0;
         s1_ff            <= 1'b0;
         s2_ff            <= 1'b0;
         s3_ff            <= 1'b0;
         s4_ff            <= 1'b0;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               pfp_pkg::CSR_HEADER_FIRST:  header_first_ff  <= csr_wdata;
               pfp_pkg::CSR_HEADER_SECOND: header_second_ff <= csr_wdata;
               pfp_pkg::CSR_TAIL_FIRST:    tail_first_ff    <= csr_wdata;
               pfp_pkg::CSR_TAIL_SECOND:   tail_second_ff   <= csr_wdata;
               default: ;
            endcase
         end
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         last_yaw_ff   <= last_yaw_in;
         acc_x_ff      <= acc_x_in;
         acc_y_ff      <= acc_y_in;
         acc_yaw_ff    <= acc_yaw_in;
         s1_ff         <= frame_done;
         s2_ff         <= s1_ff;
         s3_ff         <= s2_ff;
         s4_ff         <= s3_ff;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pay_we) payload_ff[cnt_ff] <= req_tdata;
      now_x_ff   <= now_x_in;
      now_y_ff   <= now_y_in;
      now_yaw_ff <= now_yaw_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      dyaw_ff    <= dyaw_in;
      sum_x_ff   <= sum_x_in;
      sum_y_ff   <= sum_y_in;
      sum_yaw_ff <= sum_yaw_in;
      angle_ff   <= angle_in;
      prod_ff    <= prod_in;
      rad_ff     <= rad_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {dyaw_ff, dy_ff, dx_ff, sum_y_ff, sum_x_ff, rad_ff, angle_ff};

   // at most one result in flight
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      $onehot0({s1_ff, s2_ff, s3_ff, s4_ff, rsp_tvalid_ff}))
      else $error("more than one result in flight");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      restart |=> (acc_x_ff == '0) && (acc_y_ff == '0) && (acc_yaw_ff == '0))
      else $error("restart did not clear sums");

   a_s1_from_tail: assert property (@(posedge clock) disable iff (reset)
      s1_ff |-> $past(frame_done))
      else $error("sum stage started without a completed frame");

   a_stall_only_tail: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (phase_ff == PH_TAIL1) && busy)
      else $error("input stalled outside the second tail byte");

endmodule

`default_nettype wire
